>>> rtl/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg
// types, constants and calendar helpers shared by the day difference block
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned COUNT_W     = 22;
  localparam int unsigned MOD_W       = 9;   // holds year mod 400
  localparam int unsigned ITER_W      = 3;

  localparam int unsigned YEAR_CYCLE  = 400;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned MAX_YEAR    = 9999;
  localparam int unsigned MONTHS      = 12;
  localparam int unsigned LEAP_FEB    = 29;
  // shift-subtract passes that bring any 14 bit year below 400
  localparam int unsigned REDUCE_STEPS = 6;

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
    logic               include_end_day;
  } ddd_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               valid_res;
  } ddd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } ddd_state_t;

  typedef struct packed {
    logic              load;
    logic              reduce;
    logic [ITER_W-1:0] shift;
    logic              check;
    logic              step;
  } ddd_cmd_t;

  typedef struct packed {
    logic dates_ok;
    logic date_eq;
  } ddd_stat_t;

  // leap year from year mod 400
  function automatic logic leap_of(input logic [MOD_W-1:0] r);
    logic c;
    c = (r == MOD_W'(CENTURY)) || (r == MOD_W'(2 * CENTURY)) ||
        (r == MOD_W'(3 * CENTURY));
    return (r[1:0] == 2'b00) && !c;
  endfunction

  // month length, zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                   n = DAY_W'(30);
      4'd2:    n = leap ? DAY_W'(LEAP_FEB) : DAY_W'(28);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/date_day_difference_top.sv
// ----------------------------------------------------------------------------
// date_day_difference_top
// absolute gregorian day difference between two dates, by day stepping
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result beat has gone out. For two well formed dates that lie N
// days apart (N from 0 to 3652058) the day stepper advances the earlier date
// by one day per cycle until it meets the later one, after the year mod 400
// reduction passes and the date check. A malformed item is answered with
// valid_res low and a zero count. The next item can be taken in the cycle
// right after the result beat. The result sits on out_data for exactly one
// cycle, marked by out_strobe, and the receiver must take it then: the block
// never holds a result back and cannot be stalled.
// ----------------------------------------------------------------------------
module date_day_difference_top import ddd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ddd_in_t  in_data,
  output logic     out_strobe,
  output ddd_out_t out_data
);

  ddd_cmd_t  cmd;    // controller to datapath
  ddd_stat_t stat;   // datapath to controller

  // sequencer
  ddd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // calendar datapath
  ddd_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef SYNTH
  // an accepted beat always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accept did not raise busy");

  // a result beat lasts one cycle and frees the block right after
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result beat longer than one cycle");

  // malformed item carries a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.valid_res |-> out_data.day_count == '0)
    else $error("nonzero count on malformed item");

  // no result beat without an item in flight
  a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat while idle");
`endif

endmodule

>>> rtl/ddd_ctrl.sv
// ----------------------------------------------------------------------------
// ddd_ctrl
// sequencer: year reduction passes, check, day stepping, result beat
// ----------------------------------------------------------------------------
module ddd_ctrl import ddd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ddd_stat_t stat,
  output ddd_cmd_t  cmd,
  output logic      busy,
  output logic      out_strobe
);

  ddd_state_t        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_REDUCE;
          iter_nxt  = ITER_W'(REDUCE_STEPS - 1);
        end
      end
      ST_REDUCE: begin
        if (iter_r == '0) state_nxt = ST_CHECK;
        else              iter_nxt  = iter_r - 1'b1;
      end
      ST_CHECK: begin
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (!stat.dates_ok || stat.date_eq) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.shift  = iter_r;
    busy       = (state_r != ST_IDLE);
    out_strobe = 1'b0;
    unique case (state_r)
      ST_IDLE:   cmd.load   = start;
      ST_REDUCE: cmd.reduce = 1'b1;
      ST_CHECK:  cmd.check  = 1'b1;
      ST_STEP:   cmd.step   = stat.dates_ok && !stat.date_eq;
      ST_DONE:   out_strobe = 1'b1;
      default:   cmd        = '0;
    endcase
  end

endmodule

>>> rtl/ddd_datapath.sv
// ----------------------------------------------------------------------------
// ddd_datapath
// item capture, year mod 400 reduction, date check and one-day stepper
// ----------------------------------------------------------------------------
module ddd_datapath import ddd_pkg::*; (
  input  logic      clk,
  input  ddd_in_t   in_data,
  input  ddd_cmd_t  cmd,
  output ddd_stat_t stat,
  output ddd_out_t  out_data
);

  ddd_in_t            item_r;
  logic [YEAR_W-1:0]  rem1_r, rem2_r;
  logic [DAY_W-1:0]   step_day_r;
  logic [MONTH_W-1:0] step_month_r;
  logic [YEAR_W-1:0]  step_year_r;
  logic [MOD_W-1:0]   step_mod_r;
  logic [DAY_W+MONTH_W+YEAR_W-1:0] target_date_r;
  logic [COUNT_W-1:0] day_counter_r;
  logic               ok_r;

  // reduction pass
  logic [YEAR_W:0]    thr;
  logic [YEAR_W-1:0]  rem1_nxt, rem2_nxt;

  always_comb begin
    thr      = (YEAR_W+1)'(YEAR_CYCLE) << cmd.shift;
    rem1_nxt = ({1'b0, rem1_r} >= thr) ? rem1_r - thr[YEAR_W-1:0] : rem1_r;
    rem2_nxt = ({1'b0, rem2_r} >= thr) ? rem2_r - thr[YEAR_W-1:0] : rem2_r;
  end

  // date check
  logic [DAY_W-1:0] len1, len2;
  logic             ok1, ok2, first_later;
  logic [DAY_W+MONTH_W+YEAR_W-1:0] key1, key2;

  always_comb begin
    len1 = month_len(item_r.first_month, leap_of(rem1_r[MOD_W-1:0]));
    len2 = month_len(item_r.second_month, leap_of(rem2_r[MOD_W-1:0]));
    ok1  = (item_r.first_month >= MONTH_W'(1)) && (item_r.first_month <= MONTH_W'(MONTHS)) &&
           (item_r.first_year >= YEAR_W'(1)) && (item_r.first_year <= YEAR_W'(MAX_YEAR)) &&
           (item_r.first_day >= DAY_W'(1)) && (item_r.first_day <= len1);
    ok2  = (item_r.second_month >= MONTH_W'(1)) &&
           (item_r.second_month <= MONTH_W'(MONTHS)) &&
           (item_r.second_year >= YEAR_W'(1)) && (item_r.second_year <= YEAR_W'(MAX_YEAR)) &&
           (item_r.second_day >= DAY_W'(1)) && (item_r.second_day <= len2);
    key1 = {item_r.first_year, item_r.first_month, item_r.first_day};
    key2 = {item_r.second_year, item_r.second_month, item_r.second_day};
    first_later = (key1 >= key2);
  end

  // one-day step
  logic [DAY_W-1:0] step_len;
  logic             end_of_month, end_of_year;

  always_comb begin
    step_len     = month_len(step_month_r, leap_of(step_mod_r));
    end_of_month = (step_day_r >= step_len);
    end_of_year  = (step_month_r >= MONTH_W'(MONTHS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      rem1_r <= in_data.first_year;
      rem2_r <= in_data.second_year;
    end
    if (cmd.reduce) begin
      rem1_r <= rem1_nxt;
      rem2_r <= rem2_nxt;
    end
    if (cmd.check) begin
      ok_r          <= ok1 && ok2;
      day_counter_r <= '0;
      if (ok1 && ok2) begin
        if (first_later) begin
          target_date_r <= key1;
          step_day_r    <= item_r.second_day;
          step_month_r  <= item_r.second_month;
          step_year_r   <= item_r.second_year;
          step_mod_r    <= rem2_r[MOD_W-1:0];
        end else begin
          target_date_r <= key2;
          step_day_r    <= item_r.first_day;
          step_month_r  <= item_r.first_month;
          step_year_r   <= item_r.first_year;
          step_mod_r    <= rem1_r[MOD_W-1:0];
        end
      end
    end
    if (cmd.step) begin
      day_counter_r <= day_counter_r + 1'b1;
      if (!end_of_month) begin
        step_day_r <= step_day_r + 1'b1;
      end else begin
        step_day_r <= DAY_W'(1);
        if (!end_of_year) begin
          step_month_r <= step_month_r + 1'b1;
        end else begin
          step_month_r <= MONTH_W'(1);
          step_year_r  <= step_year_r + 1'b1;
          step_mod_r   <= (step_mod_r == MOD_W'(YEAR_CYCLE - 1)) ? '0
                                                                 : step_mod_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat.dates_ok = ok_r;
    stat.date_eq  = ({step_year_r, step_month_r, step_day_r} == target_date_r);
    out_data.valid_res = ok_r;
    out_data.day_count = ok_r ? day_counter_r + COUNT_W'(item_r.include_end_day) : '0;
  end

endmodule
